/* src/rc_pwm_pulse_decoder_assert.svh */
// Assertion macros for the RC pulse decoder.
`ifndef RC_PWM_PULSE_DECODER_ASSERT_SVH
`define RC_PWM_PULSE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define RCPD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcpd assertion failed");

// Next-cycle implication.
`define RCPD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcpd assertion failed");

`endif

/* src/rcpd_pkg.sv */
// Shared types and constants of the RC pulse decoder.
package rcpd_pkg;

  localparam int CAP_W      = 32;
  localparam int HALF_CAP_W = 16;
  localparam int UPT_W      = 24;
  localparam int US_W       = 16;
  localparam int OUT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = CAP_W + UPT_W;
  localparam int FRAC_W     = 16;
  localparam int DVD_W      = 33;
  localparam int DVS_W      = 16;
  localparam int DIV_CNT_W  = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd33;

  localparam logic             RST_WIDE_COUNTER = 1'b1;
  localparam logic [UPT_W-1:0] RST_US_PER_TICK  = 24'd65536;
  localparam logic [US_W-1:0]  RST_PERIOD       = 16'd20000;
  localparam logic [US_W-1:0]  RST_NEUTRAL      = 16'd1500;
  localparam logic [US_W-1:0]  RST_FULL_FWD     = 16'd2000;
  localparam logic [US_W-1:0]  RST_FULL_REV     = 16'd1000;
  localparam logic [US_W-1:0]  RST_FWD_MAG      = 16'd100;
  localparam logic [US_W-1:0]  RST_REV_MAG      = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE_COUNTER = 3'd0,
    CFG_US_PER_TICK  = 3'd1,
    CFG_PERIOD       = 3'd2,
    CFG_NEUTRAL      = 3'd3,
    CFG_FULL_FWD     = 3'd4,
    CFG_FULL_REV     = 3'd5,
    CFG_FWD_MAG      = 3'd6,
    CFG_REV_MAG      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             wide_counter;
    logic [UPT_W-1:0] us_per_tick;
    logic [US_W-1:0]  signal_period_us;
    logic [US_W-1:0]  neutral_us;
    logic [US_W-1:0]  full_forward_us;
    logic [US_W-1:0]  full_reverse_us;
    logic [US_W-1:0]  forward_magnitude;
    logic [US_W-1:0]  reverse_magnitude;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_MUL1  = 8'b0000_0100,
    S_FOLD  = 8'b0000_1000,
    S_RANGE = 8'b0001_0000,
    S_MUL2  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_LOAD  = 8'b1000_0000
  } state_t;

endpackage

/* src/rcpd_if.sv */
// Capture and result channel interfaces.
interface rcpd_capture_if;
  logic                       valid;
  logic                       ready;
  logic [rcpd_pkg::CAP_W-1:0] capture_time;
  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface rcpd_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [rcpd_pkg::OUT_W-1:0] pulse_width_us;
  logic signed [rcpd_pkg::OUT_W-1:0] command_value;
  logic                              range_error;
  modport source (output valid, output pulse_width_us, output command_value,
                  output range_error, input ready);
  modport sink   (input valid, input pulse_width_us, input command_value,
                  input range_error, output ready);
endinterface

/* src/rcpd_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module rcpd_div (
  input  logic               clk,
  input  logic               rst,
  input  rcpd_pkg::div_req_t req,
  output rcpd_pkg::div_rsp_t rsp
);

  logic [rcpd_pkg::DVS_W-1:0]     rem;
  logic [rcpd_pkg::DVD_W-1:0]     quo;
  logic [rcpd_pkg::DVS_W-1:0]     dvs;
  logic [rcpd_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [rcpd_pkg::DVS_W:0]       shifted;
  logic                           ge;

  assign shifted = {rem, quo[rcpd_pkg::DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= rcpd_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? rcpd_pkg::DVS_W'(shifted - {1'b0, dvs}) : shifted[rcpd_pkg::DVS_W-1:0];
      quo <= {quo[rcpd_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* src/rcpd_core.sv */
// Sequencer, shared multiplier and result register of the pulse decoder.
`include "rc_pwm_pulse_decoder_assert.svh"

module rcpd_core (
  input  logic                   clk,
  input  logic                   rst,
  input  rcpd_pkg::cfg_t         cfg,
  rcpd_capture_if.sink           capture,
  rcpd_result_if.source          result,
  output rcpd_pkg::div_req_t     div_req,
  input  rcpd_pkg::div_rsp_t     div_rsp
);

  rcpd_pkg::state_t state;

  logic                        awaiting_first;
  logic [rcpd_pkg::CAP_W-1:0]  first_time;
  logic [rcpd_pkg::CAP_W-1:0]  t_cap;
  logic [rcpd_pkg::CAP_W-1:0]  op_a;
  logic [rcpd_pkg::UPT_W-1:0]  op_b;
  logic [rcpd_pkg::PROD_W-1:0] prod;
  logic signed [16:0]          width;
  logic [rcpd_pkg::DVS_W-1:0]  divisor;
  logic [rcpd_pkg::US_W-1:0]   mag;
  logic                        reverse;
  logic                        err;
  logic signed [16:0]          cmd;
  logic                        div_start;

  logic [rcpd_pkg::CAP_W-1:0] mask;
  logic [rcpd_pkg::CAP_W-1:0] t_masked;
  logic                       accept;
  logic [rcpd_pkg::US_W-1:0]  us_sat;
  logic signed [16:0]         width_next;
  logic signed [17:0]         centred;
  logic [17:0]                centred_abs;
  logic signed [16:0]         range_sel;
  logic                       range_bad;
  logic [rcpd_pkg::US_W-1:0]  cap_mag;
  logic                       load;

  assign mask     = cfg.wide_counter ? {rcpd_pkg::CAP_W{1'b1}}
                                     : {{rcpd_pkg::HALF_CAP_W{1'b0}},
                                        {rcpd_pkg::HALF_CAP_W{1'b1}}};
  assign t_masked = capture.capture_time & mask;
  assign capture.ready = (state == rcpd_pkg::S_IDLE);
  assign accept   = capture.valid && capture.ready;

  assign us_sat = (prod[rcpd_pkg::PROD_W-1:rcpd_pkg::CAP_W] != '0) ? 16'hffff
                  : prod[rcpd_pkg::FRAC_W+rcpd_pkg::US_W-1:rcpd_pkg::FRAC_W];
  assign width_next = (us_sat > {1'b0, cfg.signal_period_us[15:1]})
                      ? $signed({1'b0, cfg.signal_period_us} - {1'b0, us_sat})
                      : $signed({1'b0, us_sat});

  assign centred     = $signed({width[16], width}) - $signed({2'b00, cfg.neutral_us});
  assign centred_abs = centred[17] ? 18'(-centred) : 18'(centred);
  assign range_sel   = centred[17]
                       ? $signed({1'b0, cfg.neutral_us} - {1'b0, cfg.full_reverse_us})
                       : $signed({1'b0, cfg.full_forward_us} - {1'b0, cfg.neutral_us});
  assign range_bad   = range_sel[16] || (range_sel == '0);

  assign cap_mag = (div_rsp.quotient > {17'b0, mag}) ? mag
                   : div_rsp.quotient[rcpd_pkg::US_W-1:0];

  assign load = (state == rcpd_pkg::S_LOAD) && (!result.valid || result.ready);

  assign div_req.start    = div_start;
  assign div_req.dividend = prod[rcpd_pkg::DVD_W-1:0];
  assign div_req.divisor  = divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rcpd_pkg::S_IDLE;
      awaiting_first <= 1'b1;
      first_time     <= '0;
      div_start      <= 1'b0;
      result.valid   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        rcpd_pkg::S_IDLE: begin
          if (accept) begin
            awaiting_first <= !awaiting_first;
            if (awaiting_first) begin
              first_time <= t_masked;
            end else begin
              state <= rcpd_pkg::S_DIFF;
            end
          end
        end
        rcpd_pkg::S_DIFF:  state <= rcpd_pkg::S_MUL1;
        rcpd_pkg::S_MUL1:  state <= rcpd_pkg::S_FOLD;
        rcpd_pkg::S_FOLD:  state <= rcpd_pkg::S_RANGE;
        rcpd_pkg::S_RANGE: state <= range_bad ? rcpd_pkg::S_LOAD : rcpd_pkg::S_MUL2;
        rcpd_pkg::S_MUL2: begin
          state     <= rcpd_pkg::S_DIV;
          div_start <= 1'b1;
        end
        rcpd_pkg::S_DIV: begin
          if (div_rsp.done) begin
            state <= rcpd_pkg::S_LOAD;
          end
        end
        rcpd_pkg::S_LOAD: begin
          if (load) begin
            state <= rcpd_pkg::S_IDLE;
          end
        end
        default: state <= rcpd_pkg::S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      t_cap <= t_masked;
    end
    if (state == rcpd_pkg::S_DIFF) begin
      op_a <= (t_cap - (first_time & mask)) & mask;
      op_b <= cfg.us_per_tick;
    end
    if (state == rcpd_pkg::S_MUL1 || state == rcpd_pkg::S_MUL2) begin
      prod <= op_a * op_b;
    end
    if (state == rcpd_pkg::S_FOLD) begin
      width <= width_next;
    end
    if (state == rcpd_pkg::S_RANGE) begin
      op_a    <= {14'b0, centred_abs};
      op_b    <= {8'b0, centred[17] ? cfg.reverse_magnitude : cfg.forward_magnitude};
      mag     <= centred[17] ? cfg.reverse_magnitude : cfg.forward_magnitude;
      reverse <= centred[17];
      divisor <= range_sel[rcpd_pkg::DVS_W-1:0];
      err     <= range_bad;
      if (range_bad) begin
        cmd <= '0;
      end
    end
    if (state == rcpd_pkg::S_DIV && div_rsp.done) begin
      cmd <= reverse ? $signed(-{1'b0, cap_mag}) : $signed({1'b0, cap_mag});
    end
    if (load) begin
      result.pulse_width_us <= width;
      result.command_value  <= cmd;
      result.range_error    <= err;
    end
  end

  `RCPD_ASSERT_IMP(a_err_zero_cmd, clk, rst, result.valid && result.range_error, result.command_value == '0)
  `RCPD_ASSERT_IMP(a_fwd_cap, clk, rst, result.valid && !result.command_value[16], result.command_value[15:0] <= cfg.forward_magnitude)
  `RCPD_ASSERT_IMP(a_div_done_state, clk, rst, div_rsp.done, state == rcpd_pkg::S_DIV)
  `RCPD_ASSERT_NXT(a_first_stored, clk, rst, accept && awaiting_first, !awaiting_first && state == rcpd_pkg::S_IDLE)

endmodule

/* src/rc_pwm_pulse_decoder.sv */
// RC pulse decoder top level: configuration registers and unit wiring.
//
// Usage:
//  capture: timer capture values, valid/ready; a transfer happens when both
//    are high. Captures are taken in pairs; the first of a pair is stored and
//    gives no result, the second gives one result on the result channel.
//  result: pulse_width_us, command_value, range_error, valid/ready.
//  cfg_wr_en/cfg_index/cfg_wdata: register write port, one write per cycle;
//    the user, not the block, keeps them to when no capture pair is in flight.
//  Sequence: the first capture of a pair is stored in the idle state. The
//    second passes through DIFF, MUL1, FOLD, RANGE, MUL2, DIV and LOAD (from
//    RANGE straight to LOAD when the range is not positive), using one
//    shared multiplier twice and a 33-step radix-2 divider. capture.ready is
//    low from the second transfer until the result is loaded.
//  Reset: the configuration registers return to their defaults and the next
//    capture is the first of a pair.
//  Stall: a result waits in the output register; the next first capture is
//    still taken, and a second one waits in the load step until the result
//    is transferred.
module rc_pwm_pulse_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rcpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  rcpd_capture_if.sink                       capture,
  rcpd_result_if.source                      result
);

  rcpd_pkg::cfg_t     cfg;
  rcpd_pkg::div_req_t div_req;
  rcpd_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wide_counter      <= rcpd_pkg::RST_WIDE_COUNTER;
      cfg.us_per_tick       <= rcpd_pkg::RST_US_PER_TICK;
      cfg.signal_period_us  <= rcpd_pkg::RST_PERIOD;
      cfg.neutral_us        <= rcpd_pkg::RST_NEUTRAL;
      cfg.full_forward_us   <= rcpd_pkg::RST_FULL_FWD;
      cfg.full_reverse_us   <= rcpd_pkg::RST_FULL_REV;
      cfg.forward_magnitude <= rcpd_pkg::RST_FWD_MAG;
      cfg.reverse_magnitude <= rcpd_pkg::RST_REV_MAG;
    end else if (cfg_wr_en) begin
      unique case (rcpd_pkg::cfg_idx_t'(cfg_index))
        rcpd_pkg::CFG_WIDE_COUNTER: cfg.wide_counter      <= cfg_wdata[0];
        rcpd_pkg::CFG_US_PER_TICK:  cfg.us_per_tick       <= cfg_wdata;
        rcpd_pkg::CFG_PERIOD:       cfg.signal_period_us  <= cfg_wdata[15:0];
        rcpd_pkg::CFG_NEUTRAL:      cfg.neutral_us        <= cfg_wdata[15:0];
        rcpd_pkg::CFG_FULL_FWD:     cfg.full_forward_us   <= cfg_wdata[15:0];
        rcpd_pkg::CFG_FULL_REV:     cfg.full_reverse_us   <= cfg_wdata[15:0];
        rcpd_pkg::CFG_FWD_MAG:      cfg.forward_magnitude <= cfg_wdata[15:0];
        rcpd_pkg::CFG_REV_MAG:      cfg.reverse_magnitude <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  rcpd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .capture (capture),
    .result  (result),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  rcpd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

/* sim/rc_pwm_pulse_decoder_tb.sv */
// Testbench for the RC pulse decoder: capture pairs checked against a local decode model.
module rc_pwm_pulse_decoder_tb;
  import rcpd_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int PAIRS_PER_PHASE = 51;
  localparam int RANDOM_PHASES   = 16;
  localparam int PRINT_LIMIT     = 100;

  typedef struct packed {
    logic [OUT_W-1:0] width;
    logic [OUT_W-1:0] command;
    logic             err;
  } decode_t;

  typedef enum int {RDY_OPEN, RDY_SPOTTY, RDY_LONG} rdy_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rcpd_capture_if cap_if ();
  rcpd_result_if  res_if ();

  rc_pwm_pulse_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .capture   (cap_if),
    .result    (res_if)
  );

  cfg_t             model_cfg;
  logic             awaiting_first;
  logic [CAP_W-1:0] first_stamp;
  logic [CAP_W-1:0] capture_q[$];
  decode_t          decode_q[$];
  int               mismatches = 0;
  int               cycles = 0;
  int               gap_left = 0;
  int               burst_left = 0;
  int               rdy_left = 0;
  int               rdy_epoch = 0;
  rdy_mode_t        rdy_mode = RDY_OPEN;
  logic             rdy_next;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic decode_t decode_pulse(logic [CAP_W-1:0] ticks);
    longint unsigned us;
    longint          w, centred, span, mag, v;
    decode_t         d;
    us = (64'(ticks) * 64'(model_cfg.us_per_tick)) >> FRAC_W;
    if (us > 65535) us = 65535;
    w = longint'(us);
    if (w > longint'(model_cfg.signal_period_us >> 1))
      w = longint'(model_cfg.signal_period_us) - w;
    centred = w - longint'(model_cfg.neutral_us);
    d.err = 1'b0;
    if (centred >= 0) begin
      span = longint'(model_cfg.full_forward_us) - longint'(model_cfg.neutral_us);
      mag  = longint'(model_cfg.forward_magnitude);
      if (span <= 0) begin
        v = 0;
        d.err = 1'b1;
      end else begin
        v = centred * mag / span;
        if (v > mag) v = mag;
      end
    end else begin
      span = longint'(model_cfg.neutral_us) - longint'(model_cfg.full_reverse_us);
      mag  = longint'(model_cfg.reverse_magnitude);
      if (span <= 0) begin
        v = 0;
        d.err = 1'b1;
      end else begin
        v = -((-centred) * mag / span);
        if (v < -mag) v = -mag;
      end
    end
    d.width   = w[OUT_W-1:0];
    d.command = v[OUT_W-1:0];
    return d;
  endfunction

  task automatic take_capture(logic [CAP_W-1:0] raw);
    logic [CAP_W-1:0] mask, t;
    mask = model_cfg.wide_counter ? {CAP_W{1'b1}} : {{HALF_CAP_W{1'b0}}, {HALF_CAP_W{1'b1}}};
    t = raw & mask;
    if (awaiting_first) begin
      first_stamp = t;
      awaiting_first = 1'b0;
    end else begin
      decode_q.push_back(decode_pulse((t - (first_stamp & mask)) & mask));
      awaiting_first = 1'b1;
    end
  endtask

  function automatic cfg_t pick_settings(int phase);
    cfg_t c;
    int   roll;
    case (phase)
      0: c = '{1'b1, '1, '1, '1, '1, '1, '1, '1};
      1: c = '{1'b0, UPT_W'(1), US_W'(1), '0, '0, '0, '0, '0};
      2: c = '{1'b1, '1, '1, US_W'(32768), '1, '0, '1, '1};
      3: c = '{1'b0, RST_US_PER_TICK, RST_PERIOD, RST_NEUTRAL, RST_FULL_FWD, RST_FULL_REV,
               RST_FWD_MAG, RST_REV_MAG};
      default: begin
        c.wide_counter = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 19);
        if (roll == 0) c.us_per_tick = '0;
        else if (roll < 6) c.us_per_tick = RST_US_PER_TICK;
        else if (roll < 10) c.us_per_tick = UPT_W'($urandom_range(1, 3)) << 15;
        else if (roll < 16) c.us_per_tick = UPT_W'($urandom_range(256, 1 << 20));
        else c.us_per_tick = UPT_W'($urandom_range(1, (1 << UPT_W) - 1));
        c.signal_period_us = US_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                               : $urandom_range(2500, 30000));
        c.neutral_us = US_W'($urandom_range(900, 2100));
        c.full_forward_us = US_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                  : c.neutral_us + $urandom_range(1, 900));
        c.full_reverse_us = US_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                  : c.neutral_us - $urandom_range(1, 800));
        c.forward_magnitude = US_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 1000));
        c.reverse_magnitude = US_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 1000));
      end
    endcase
    return c;
  endfunction

  // bits above the register width are junk and must be dropped by the block
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val, int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom()) << w;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= ($urandom_range(0, 1) == 1) ? (val | junk) : val;
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(CFG_WIDE_COUNTER, CFG_DATA_W'(c.wide_counter), 1);
    write_reg(CFG_US_PER_TICK, c.us_per_tick, UPT_W);
    write_reg(CFG_PERIOD, CFG_DATA_W'(c.signal_period_us), US_W);
    write_reg(CFG_NEUTRAL, CFG_DATA_W'(c.neutral_us), US_W);
    write_reg(CFG_FULL_FWD, CFG_DATA_W'(c.full_forward_us), US_W);
    write_reg(CFG_FULL_REV, CFG_DATA_W'(c.full_reverse_us), US_W);
    write_reg(CFG_FWD_MAG, CFG_DATA_W'(c.forward_magnitude), US_W);
    write_reg(CFG_REV_MAG, CFG_DATA_W'(c.reverse_magnitude), US_W);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_cfg = c;
  endtask

  task automatic add_pair(logic [CAP_W-1:0] a, logic [CAP_W-1:0] b);
    capture_q.push_back(a);
    capture_q.push_back(b);
  endtask

  // mostly plausible widths, some at the fold point, some saturating, some noise
  task automatic queue_pairs(int n);
    logic [CAP_W-1:0] first;
    longint           target, ticks;
    int               pick;
    for (int i = 0; i < n; i++) begin
      first = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 60)
        target = longint'(model_cfg.neutral_us) + longint'($urandom_range(0, 2400)) - 1200;
      else if (pick < 80)
        target = longint'(model_cfg.signal_period_us >> 1) + longint'($urandom_range(0, 6)) - 3;
      else
        target = longint'($urandom_range(0, 70000));
      if (target < 0) target = 0;
      if (model_cfg.us_per_tick == 0)
        ticks = longint'($urandom());
      else
        ticks = ((target << FRAC_W)
                 + longint'($urandom_range(0, model_cfg.us_per_tick - 1)))
                / longint'(model_cfg.us_per_tick);
      if (pick >= 90) add_pair(first, $urandom());
      else add_pair(first, first + ticks[CAP_W-1:0]);
    end
  endtask

  task automatic drain();
    while (capture_q.size() != 0 || cap_if.valid || decode_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report(string what, logic signed [OUT_W-1:0] got,
                        logic signed [OUT_W-1:0] exp);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch %s: got %0d expected %0d, cycle %0d", what, got, exp, cycles);
    mismatches++;
  endtask

  task automatic check_result();
    decode_t exp;
    if (decode_q.size() == 0) begin
      report("unexpected result", res_if.pulse_width_us, '0);
      return;
    end
    exp = decode_q.pop_front();
    if (res_if.pulse_width_us !== exp.width)
      report("pulse_width_us", res_if.pulse_width_us, exp.width);
    if (res_if.command_value !== exp.command)
      report("command_value", res_if.command_value, exp.command);
    if (res_if.range_error !== exp.err)
      report("range_error", OUT_W'(res_if.range_error), OUT_W'(exp.err));
  endtask

  // capture driver
  always @(posedge clk) begin
    if (rst) begin
      cap_if.valid <= 1'b0;
    end else begin
      if (cap_if.valid && cap_if.ready) take_capture(cap_if.capture_time);
      if (!cap_if.valid || cap_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cap_if.valid <= 1'b0;
        end else if (capture_q.size() != 0) begin
          cap_if.valid <= 1'b1;
          cap_if.capture_time <= capture_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          cap_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready pattern
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) check_result();
      rdy_epoch++;
      if (rdy_epoch == 700) begin
        rdy_epoch = 0;
        rdy_mode = rdy_mode_t'($urandom_range(0, 2));
      end
      if (rdy_left > 0) begin
        rdy_left--;
      end else begin
        case (rdy_mode)
          RDY_OPEN: begin
            rdy_next = 1'b1;
            rdy_left = $urandom_range(1, 60);
          end
          RDY_SPOTTY: begin
            rdy_next = ($urandom_range(0, 3) != 0);
            rdy_left = $urandom_range(0, 2);
          end
          default: begin
            rdy_next = !res_if.ready;
            rdy_left = rdy_next ? $urandom_range(0, 4) : $urandom_range(1, 40);
          end
        endcase
        res_if.ready <= rdy_next;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** rc_pwm_pulse_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    cfg_t narrow_cfg;
    cap_if.valid = 1'b0;
    cap_if.capture_time = '0;
    res_if.ready = 1'b0;
    model_cfg = '{RST_WIDE_COUNTER, RST_US_PER_TICK, RST_PERIOD, RST_NEUTRAL, RST_FULL_FWD,
                  RST_FULL_REV, RST_FWD_MAG, RST_REV_MAG};
    awaiting_first = 1'b1;
    first_stamp = '0;
    narrow_cfg = '{1'b0, RST_US_PER_TICK, US_W'(65535), RST_NEUTRAL, RST_NEUTRAL,
                   US_W'(2000), '1, '1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // defaults: 1 us per tick, neutral 1500, range 1000..2000, cap 100
    add_pair(32'h0000_0000, 32'h0000_0000);
    add_pair(32'hFFFF_FE00, 32'h0000_03DC);
    add_pair(32'd1000, 32'd3000);
    add_pair(32'd5, 32'd1005);
    add_pair(32'd100, 32'd1850);
    add_pair(32'd0, 32'd1499);
    add_pair(32'hFFFF_FFFF, 32'd2499);
    add_pair(32'd0, 32'd18500);
    add_pair(32'd0, 32'd10000);
    add_pair(32'd0, 32'd10001);
    add_pair(32'd0, 32'hFFFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'd0);
    drain();

    // narrow counter, zero forward range, negative reverse range
    program_regs(narrow_cfg);
    add_pair(32'h1234_FFF0, 32'hABCD_0010);
    add_pair(32'h0000_0000, 32'h0001_05DC);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_regs(pick_settings(p));
      queue_pairs(PAIRS_PER_PHASE);
      drain();
    end

    if (mismatches == 0) begin
      $display("** rc_pwm_pulse_decoder: PASSED **");
    end else begin
      $display("** rc_pwm_pulse_decoder: FAILED **");
    end
    $finish;
  end

endmodule
